/* src/mlr_pkg.sv */
// Shared constants, codes and types for the midpoint line rasteriser.
`timescale 1ns / 1ps

package mlr_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COLOR_BITS     = 8;
  // headroom bits of the signed decision term above the coordinate width
  localparam int DEC_EXT        = 3;

  localparam logic [COLOR_BITS-1:0] PEN_RESET = 8'hFF;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic steep;
    logic walk_down;
    logic last;
  } mlr_flags_t;

endpackage

/* src/midpoint_line_raster_top.sv */
// Top level of the midpoint line rasteriser: input register, line state, result register.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser op; tdata x_start,y_start,x_end,y_end
//  out_    | out | out_tvalid/out_tready| tdata pixel_x,pixel_y,pixel_color; tlast last
//  cfg_    | in  | cfg_tvalid/cfg_tready| tdata pen_color
//
// An item passes through the input register and then the result register, one item per
// cycle sustained while the result is not stalled. The rate is set by the combinational
// setup and step adders feeding the line state registers.
// Synchronous active-low reset empties both registers, ends any line and sets the pen
// to its reset colour. A stalled result holds the input register; the input register
// still drains an advance that arrives with no line active, as it makes no pixel.
`timescale 1ns / 1ps

module midpoint_line_raster_top #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + mlr_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // x_start, y_start, x_end, y_end
  input  logic                           in_tuser,   // op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // pixel_x, pixel_y, pixel_color
  output logic                           out_tlast,  // last_pixel
  input  logic                           cfg_tvalid,
  output logic                           cfg_tready,
  input  logic [mlr_pkg::COLOR_BITS-1:0] cfg_tdata   // pen_color
);
  import mlr_pkg::*;

  localparam int C        = COORD_BITS;
  localparam int DEC_BITS = COORD_BITS + DEC_EXT;

  // input register
  logic                  in_valid_r;
  logic                  in_op_r;
  logic [C-1:0]          xs_r, ys_r, xe_r, ye_r;

  // line state
  logic                       busy_r;
  logic [C-1:0]               major_pos_r, minor_pos_r, major_stop_r;
  logic [C-1:0]               major_delta_r, minor_delta_r;
  logic signed [DEC_BITS-1:0] decision_r;
  logic                       steep_r, walk_down_r;

  // result register
  logic                  out_valid_r;
  logic [C-1:0]          out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_last_r;

  logic [COLOR_BITS-1:0] pen_color_r;

  // setup results
  logic [C-1:0]               su_major_pos, su_minor_pos, su_major_stop;
  logic [C-1:0]               su_major_delta, su_minor_delta;
  logic signed [DEC_BITS-1:0] su_decision;
  mlr_flags_t                 su_flags;

  // step results
  logic [C-1:0]               st_major_pos, st_minor_pos;
  logic signed [DEC_BITS-1:0] st_decision;
  logic                       st_last;

  logic is_start, emits, out_free, proc;
  logic [C-1:0] new_major, new_minor;
  logic         new_steep, new_last;

  mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x_start     (xs_r),
    .y_start     (ys_r),
    .x_end       (xe_r),
    .y_end       (ye_r),
    .major_pos   (su_major_pos),
    .minor_pos   (su_minor_pos),
    .major_stop  (su_major_stop),
    .major_delta (su_major_delta),
    .minor_delta (su_minor_delta),
    .decision    (su_decision),
    .flags       (su_flags)
  );

  mlr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .major_pos     (major_pos_r),
    .minor_pos     (minor_pos_r),
    .major_stop    (major_stop_r),
    .major_delta   (major_delta_r),
    .minor_delta   (minor_delta_r),
    .decision      (decision_r),
    .walk_down     (walk_down_r),
    .major_pos_nxt (st_major_pos),
    .minor_pos_nxt (st_minor_pos),
    .decision_nxt  (st_decision),
    .last          (st_last)
  );

  always_comb begin
    is_start  = (in_op_r == OP_START);
    emits     = in_valid_r && (is_start || busy_r);
    out_free  = !out_valid_r || out_tready;
    proc      = in_valid_r && (!emits || out_free);
    in_tready = !in_valid_r || proc;
    cfg_tready = 1'b1;

    new_major = is_start ? su_major_pos : st_major_pos;
    new_minor = is_start ? su_minor_pos : st_minor_pos;
    new_steep = is_start ? su_flags.steep : steep_r;
    new_last  = is_start ? su_flags.last : st_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      pen_color_r <= PEN_RESET;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        pen_color_r <= cfg_tdata;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proc && emits) begin
        out_valid_r <= 1'b1;
        busy_r      <= !new_last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r <= in_tuser;
      xs_r    <= in_tdata[C-1:0];
      ys_r    <= in_tdata[2*C-1:C];
      xe_r    <= in_tdata[3*C-1:2*C];
      ye_r    <= in_tdata[4*C-1:3*C];
    end
    if (proc && emits) begin
      major_pos_r <= new_major;
      minor_pos_r <= new_minor;
      if (is_start) begin
        major_stop_r  <= su_major_stop;
        major_delta_r <= su_major_delta;
        minor_delta_r <= su_minor_delta;
        decision_r    <= su_decision;
        steep_r       <= su_flags.steep;
        walk_down_r   <= su_flags.walk_down;
      end else begin
        decision_r <= st_decision;
      end
      out_x_r     <= new_steep ? new_minor : new_major;
      out_y_r     <= new_steep ? new_major : new_minor;
      out_color_r <= pen_color_r;
      out_last_r  <= new_last;
    end
  end

  always_comb begin
    out_tvalid = out_valid_r;
    out_tlast  = out_last_r;
    out_tdata  = '0;
    out_tdata[C-1:0]                      = out_x_r;
    out_tdata[2*C-1:C]                    = out_y_r;
    out_tdata[2*C+COLOR_BITS-1:2*C]       = out_color_r;
  end

endmodule

/* src/mlr_setup.sv */
// Line setup: axis swap, endpoint ordering, deltas and first decision for a start item.
`timescale 1ns / 1ps

module mlr_setup #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]                   x_start,
  input  logic [COORD_BITS-1:0]                   y_start,
  input  logic [COORD_BITS-1:0]                   x_end,
  input  logic [COORD_BITS-1:0]                   y_end,
  output logic [COORD_BITS-1:0]                   major_pos,
  output logic [COORD_BITS-1:0]                   minor_pos,
  output logic [COORD_BITS-1:0]                   major_stop,
  output logic [COORD_BITS-1:0]                   major_delta,
  output logic [COORD_BITS-1:0]                   minor_delta,
  output logic signed [COORD_BITS+mlr_pkg::DEC_EXT-1:0] decision,
  output mlr_pkg::mlr_flags_t                     flags
);
  import mlr_pkg::*;

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] pa, qa, pb, qb;
  logic [COORD_BITS-1:0] p1, q1, p2, q2;
  logic                  steep, swap, rising;

  always_comb begin
    dx = (x_end > x_start) ? x_end - x_start : x_start - x_end;
    dy = (y_end > y_start) ? y_end - y_start : y_start - y_end;
    steep = dx < dy;

    pa = steep ? y_start : x_start;
    qa = steep ? x_start : y_start;
    pb = steep ? y_end   : x_end;
    qb = steep ? x_end   : y_end;

    // order along the major axis
    swap = pa > pb;
    p1 = swap ? pb : pa;
    q1 = swap ? qb : qa;
    p2 = swap ? pa : pb;
    q2 = swap ? qa : qb;

    major_delta = p2 - p1;
    rising      = q1 < q2;
    major_pos   = rising ? p1 : p2;
    minor_pos   = rising ? q1 : q2;
    major_stop  = rising ? p2 : p1;
    minor_delta = rising ? q2 - q1 : q1 - q2;

    decision = $signed({{DEC_EXT{1'b0}}, major_delta >> 1})
             - $signed({{DEC_EXT{1'b0}}, minor_delta});

    flags.steep     = steep;
    flags.walk_down = !rising;
    flags.last      = (major_pos == major_stop);
  end

endmodule

/* src/mlr_step.sv */
// One advance of the midpoint walk: major step, conditional minor step, decision update.
`timescale 1ns / 1ps

module mlr_step #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]                         major_pos,
  input  logic [COORD_BITS-1:0]                         minor_pos,
  input  logic [COORD_BITS-1:0]                         major_stop,
  input  logic [COORD_BITS-1:0]                         major_delta,
  input  logic [COORD_BITS-1:0]                         minor_delta,
  input  logic signed [COORD_BITS+mlr_pkg::DEC_EXT-1:0] decision,
  input  logic                                          walk_down,
  output logic [COORD_BITS-1:0]                         major_pos_nxt,
  output logic [COORD_BITS-1:0]                         minor_pos_nxt,
  output logic signed [COORD_BITS+mlr_pkg::DEC_EXT-1:0] decision_nxt,
  output logic                                          last
);
  import mlr_pkg::*;

  localparam int DEC_BITS = COORD_BITS + DEC_EXT;

  logic signed [DEC_BITS-1:0] major_ext, minor_ext;
  logic                       neg;

  always_comb begin
    major_ext = $signed({{DEC_EXT{1'b0}}, major_delta});
    minor_ext = $signed({{DEC_EXT{1'b0}}, minor_delta});
    neg       = decision[DEC_BITS-1];

    if (neg) begin
      minor_pos_nxt = minor_pos + 1'b1;
      decision_nxt  = decision + (major_ext - minor_ext);
    end else begin
      minor_pos_nxt = minor_pos;
      decision_nxt  = decision - minor_ext;
    end

    major_pos_nxt = walk_down ? major_pos - 1'b1 : major_pos + 1'b1;
    last          = (major_pos_nxt == major_stop);
  end

endmodule

/* src/mlr_checker.sv */
// Port-level checks for the midpoint line rasteriser, bound to the top level.
`timescale 1ns / 1ps

module mlr_checker #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ((2 * COORD_BITS + mlr_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);
  import mlr_pkg::*;

  // a stalled pixel stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // and does not change under the stall
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // every accepted start item is followed by an offered pixel after the input and result registers
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_START) |-> ##2 out_tvalid)
    else $error("start item gave no pixel");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind midpoint_line_raster_top mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
